[design/oahs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_pkg
// shared types and constants of the open addressing hash set
// ----------------------------------------------------------------------------
package oahs_pkg;

  localparam int SlotCountLog2Dflt = 10;
  localparam int KeyWidthDflt      = 64;
  localparam int HashWidthDflt     = 64;
  localparam int PerturbShift      = 5;
  localparam int CountWidth        = 11;
  localparam int StatusWidth       = 3;
  localparam int OpWidth           = 3;
  localparam int CfgWidth          = 4;
  localparam logic [CfgWidth-1:0] SizeLog2Min   = 4'd3;
  localparam logic [CfgWidth-1:0] SizeLog2Reset = 4'd3;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD      = 3'd0,
    OP_CONTAINS = 3'd1,
    OP_DISCARD  = 3'd2,
    OP_POP      = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_ADDED     = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FLAG_EMPTY  = 2'd0,
    FLAG_ACTIVE = 2'd1,
    FLAG_TOMB   = 2'd2
  } flag_e;

  // classified command kinds passed from front to back
  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_DISCARD = 3'd2,
    CMD_POP     = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_NOP     = 3'd5
  } cmd_e;

endpackage : oahs_pkg
`default_nettype wire

[design/oahs_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oahs channel interfaces
// valid/ready channels for operations, results and configuration
// ----------------------------------------------------------------------------
interface oahs_op_if
  import oahs_pkg::*;
#(
  parameter int KEY_WIDTH  = KeyWidthDflt,
  parameter int HASH_WIDTH = HashWidthDflt
);
  logic                  valid;
  logic                  ready;
  logic [OpWidth-1:0]    operation;
  logic [KEY_WIDTH-1:0]  key;
  logic [HASH_WIDTH-1:0] key_hash;
  modport source (output valid, operation, key, key_hash, input ready);
  modport sink   (input valid, operation, key, key_hash, output ready);
endinterface

interface oahs_res_if
  import oahs_pkg::*;
#(
  parameter int KEY_WIDTH = KeyWidthDflt
);
  logic                   valid;
  logic                   ready;
  logic [StatusWidth-1:0] status;
  logic [KEY_WIDTH-1:0]   key_out;
  logic [CountWidth-1:0]  element_total;
  logic                   grow_wanted;
  modport source (output valid, status, key_out, element_total, grow_wanted, input ready);
  modport sink   (input valid, status, key_out, element_total, grow_wanted, output ready);
endinterface

interface oahs_cfg_if
  import oahs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgWidth-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[design/oahs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_front
// accepts operations, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module oahs_front
  import oahs_pkg::*;
#(
  parameter int KEY_WIDTH  = KeyWidthDflt,
  parameter int HASH_WIDTH = HashWidthDflt,
  parameter int CMD_W      = 3 + KEY_WIDTH + HASH_WIDTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  oahs_op_if.sink           op,
  output logic              cmd_valid_o,
  input  wire               cmd_ready_i,
  output logic [CMD_W-1:0]  cmd_o
);

  localparam int Depth = 2;

  logic [CMD_W-1:0] fifo_q [Depth];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_e kind;
  logic push, pop;

  always_comb begin
    unique case (op.operation)
      OP_ADD:      kind = CMD_ADD;
      OP_CONTAINS: kind = CMD_LOOKUP;
      OP_DISCARD:  kind = CMD_DISCARD;
      OP_POP:      kind = CMD_POP;
      OP_CLEAR:    kind = CMD_CLEAR;
      default:     kind = CMD_NOP;
    endcase
  end

  assign op.ready    = (cnt_q != 2'(Depth));
  assign push        = op.valid && op.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= {kind, op.key, op.key_hash};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("command queue overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count");
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && !cmd_ready_i) |=> cmd_valid_o) else $error("command dropped");

endmodule : oahs_front
`default_nettype wire

[design/oahs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_back
// probe / pop / clear sequencer over the slot memories
// ----------------------------------------------------------------------------
module oahs_back
  import oahs_pkg::*;
#(
  parameter int SLOT_COUNT_LOG2 = SlotCountLog2Dflt,
  parameter int KEY_WIDTH       = KeyWidthDflt,
  parameter int HASH_WIDTH      = HashWidthDflt,
  parameter int CMD_W           = 3 + KEY_WIDTH + HASH_WIDTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cmd_valid_i,
  output logic              cmd_ready_o,
  input  wire  [CMD_W-1:0]  cmd_i,
  oahs_cfg_if.sink          cfg,
  oahs_res_if.source        res
);

  localparam int Slots = 1 << SLOT_COUNT_LOG2;
  localparam int Aw    = SLOT_COUNT_LOG2;
  localparam int Lw    = SLOT_COUNT_LOG2 + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [1:0]            flag_mem [Slots];
  logic [KEY_WIDTH-1:0]  key_mem  [Slots];
  logic [HASH_WIDTH-1:0] hash_mem [Slots];

  logic [2:0] state_q, state_d;
  logic [CountWidth-1:0] elem_q, fill_q;
  logic [Aw-1:0] finger_q;
  logic [CfgWidth-1:0] slog_q;
  logic [Aw-1:0] mask;

  cmd_e                  cmd_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [HASH_WIDTH-1:0] hash_q;
  logic [HASH_WIDTH-1:0] pert_q;
  logic [Aw-1:0]         idx_q;
  logic [Lw-1:0]         steps_q;
  logic                  tomb_v_q;
  logic [Aw-1:0]         tomb_q;
  logic [Aw-1:0]         clr_q;
  logic                  clr_pend_q;

  logic [1:0]            rd_flag_q;
  logic [KEY_WIDTH-1:0]  rd_key_q;
  logic [HASH_WIDTH-1:0] rd_hash_q;

  logic [StatusWidth-1:0] st_q;
  logic [KEY_WIDTH-1:0]   kout_q;
  logic                   res_v_q;

  logic [HASH_WIDTH-1:0] pert_nx;
  logic [Aw-1:0]         idx_nx;
  logic [Aw+2:0]         idx_mul;
  logic                  hit;
  logic [CfgWidth-1:0]   cfg_lim;
  logic [Aw+4:0]         grow_l, grow_r;

  always_comb begin
    mask = '0;
    for (int b = 0; b < Aw; b++) mask[b] = (4'(b) < slog_q);
  end

  assign pert_nx = pert_q >> PerturbShift;
  assign idx_mul = (Aw+3)'(idx_q) * (Aw+3)'(5) + (Aw+3)'(1) + (Aw+3)'(pert_nx);
  assign idx_nx  = idx_mul[Aw-1:0] & mask;
  assign hit = (rd_flag_q == FLAG_ACTIVE) && (rd_hash_q == hash_q) && (rd_key_q == key_q);

  always_comb begin
    if (cfg.data < SizeLog2Min) cfg_lim = SizeLog2Min;
    else if (cfg.data > CfgWidth'(SLOT_COUNT_LOG2)) cfg_lim = CfgWidth'(SLOT_COUNT_LOG2);
    else cfg_lim = cfg.data;
  end

  assign cfg.ready   = (state_q == S_IDLE) && !res_v_q;
  assign cmd_ready_o = (state_q == S_IDLE) && !res_v_q && !clr_pend_q;
  assign grow_l = (Aw+5)'(fill_q) * (Aw+5)'(5);
  assign grow_r = (Aw+5)'(mask) * (Aw+5)'(3);

  assign res.valid         = res_v_q;
  assign res.status        = st_q;
  assign res.key_out       = kout_q;
  assign res.element_total = elem_q;
  assign res.grow_wanted   = (grow_l >= grow_r);

  // synchronous read port, address is the current probe index
  always_ff @(posedge clk_i) begin
    rd_flag_q <= flag_mem[idx_q];
    rd_key_q  <= key_mem[idx_q];
    rd_hash_q <= hash_mem[idx_q];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (clr_pend_q) state_d = S_CLEAR;
               else if (cmd_valid_i && cmd_ready_o) begin
                 if (cmd_e'(cmd_i[CMD_W-1 -: 3]) == CMD_CLEAR) state_d = S_CLEAR;
                 else if (cmd_e'(cmd_i[CMD_W-1 -: 3]) == CMD_NOP) state_d = S_OUT;
                 // pop on an empty set answers at once
                 else if (cmd_e'(cmd_i[CMD_W-1 -: 3]) == CMD_POP && elem_q == '0)
                   state_d = S_OUT;
                 else state_d = S_READ;
               end
      S_READ:  state_d = S_EVAL;
      S_EVAL:  state_d = S_READ;
      S_CLEAR: if (clr_q == Aw'(Slots - 1)) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_EVAL) begin
      if (cmd_q == CMD_POP) begin
        if (rd_flag_q == FLAG_ACTIVE) state_d = S_OUT;
      end else if (rd_flag_q == FLAG_EMPTY || hit || steps_q == Lw'(mask) + Lw'(14)) begin
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) flag_mem[clr_q] <= FLAG_EMPTY;
    if (state_q == S_EVAL) begin
      if (cmd_q == CMD_POP && rd_flag_q == FLAG_ACTIVE) begin
        flag_mem[idx_q] <= FLAG_TOMB;
        hash_mem[idx_q] <= '0;
      end else if (cmd_q == CMD_DISCARD && hit) begin
        flag_mem[idx_q] <= FLAG_TOMB;
        hash_mem[idx_q] <= '0;
      end else if (cmd_q == CMD_ADD && !hit && rd_flag_q == FLAG_EMPTY) begin
        if (tomb_v_q) begin
          flag_mem[tomb_q] <= FLAG_ACTIVE;
          key_mem[tomb_q]  <= key_q;
          hash_mem[tomb_q] <= hash_q;
        end else if (fill_q < CountWidth'(mask)) begin
          flag_mem[idx_q] <= FLAG_ACTIVE;
          key_mem[idx_q]  <= key_q;
          hash_mem[idx_q] <= hash_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_ready_o) begin
      key_q  <= cmd_i[KEY_WIDTH+HASH_WIDTH-1 -: KEY_WIDTH];
      hash_q <= cmd_i[HASH_WIDTH-1:0];
      pert_q <= cmd_i[HASH_WIDTH-1:0];
      steps_q  <= '0;
      tomb_v_q <= 1'b0;
      if (cmd_e'(cmd_i[CMD_W-1 -: 3]) == CMD_POP) idx_q <= finger_q & mask;
      else idx_q <= Aw'(cmd_i[HASH_WIDTH-1:0]) & mask;
    end else if (state_q == S_EVAL && state_d == S_READ) begin
      steps_q <= steps_q + 1'b1;
      if (cmd_q == CMD_POP) idx_q <= (idx_q + 1'b1) & mask;
      else begin
        if (rd_flag_q == FLAG_TOMB && !tomb_v_q) begin
          tomb_v_q <= 1'b1;
          tomb_q   <= idx_q;
        end
        pert_q <= pert_nx;
        idx_q  <= idx_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      clr_pend_q <= 1'b0;
      elem_q     <= '0;
      fill_q     <= '0;
      finger_q   <= '0;
      slog_q     <= SizeLog2Reset;
      res_v_q    <= 1'b0;
      st_q       <= ST_REMOVED;
      kout_q     <= '0;
      cmd_q      <= CMD_NOP;
    end else begin
      state_q <= state_d;
      if (res.valid && res.ready) res_v_q <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        slog_q     <= cfg_lim;
        clr_pend_q <= 1'b1;
        elem_q     <= '0;
        fill_q     <= '0;
        finger_q   <= '0;
      end
      if (state_q == S_IDLE && clr_pend_q) begin
        clr_pend_q <= 1'b0;
        cmd_q      <= CMD_NOP;
        st_q       <= ST_REMOVED;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
        if (cmd_q == CMD_CLEAR) begin
          elem_q   <= '0;
          fill_q   <= '0;
          finger_q <= '0;
          st_q     <= ST_REMOVED;
          kout_q   <= '0;
        end
      end
      if (state_q == S_IDLE && cmd_valid_i && cmd_ready_o) begin
        cmd_q  <= cmd_e'(cmd_i[CMD_W-1 -: 3]);
        st_q   <= ST_NOT_FOUND;
        kout_q <= '0;
        if (cmd_e'(cmd_i[CMD_W-1 -: 3]) == CMD_POP && elem_q == '0) st_q <= ST_EMPTY;
      end
      if (state_q == S_OUT) begin
        // reset sweep and config clears produce no result
        if (!(cmd_q == CMD_NOP && st_q != ST_NOT_FOUND) && cmd_q != CMD_NOP) res_v_q <= 1'b1;
        if (cmd_q == CMD_NOP && st_q == ST_NOT_FOUND) res_v_q <= 1'b1;
      end
      if (state_q == S_EVAL) begin
        unique case (cmd_q)
          CMD_POP: if (rd_flag_q == FLAG_ACTIVE) begin
            kout_q   <= rd_key_q;
            elem_q   <= elem_q - 1'b1;
            finger_q <= idx_q + 1'b1;
            st_q     <= ST_REMOVED;
          end
          CMD_LOOKUP: if (hit) st_q <= ST_FOUND;
          CMD_DISCARD: if (hit) begin
            st_q   <= ST_REMOVED;
            elem_q <= elem_q - 1'b1;
          end
          CMD_ADD: if (hit) st_q <= ST_PRESENT;
            else if (tomb_v_q && (rd_flag_q == FLAG_EMPTY || state_d == S_OUT)) begin
              st_q   <= ST_ADDED;
              elem_q <= elem_q + 1'b1;
            end else if (rd_flag_q == FLAG_EMPTY && fill_q < CountWidth'(mask)) begin
              st_q   <= ST_ADDED;
              elem_q <= elem_q + 1'b1;
              fill_q <= fill_q + 1'b1;
            end else if (state_d == S_OUT) st_q <= ST_FULL;
          default: ;
        endcase
      end
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res.ready) |=> res.valid && $stable(res.status)) else $error("result lost");
  a_fill_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_q <= fill_q) else $error("element count above fill");
  a_no_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_ready_o) else $error("command taken while busy");

endmodule : oahs_back
`default_nettype wire

[design/open_addressing_hash_set_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_set_top
// hash set with perturbed probing over a power-of-two slot table
// ----------------------------------------------------------------------------
// channels: op (operation, key, key_hash), res (status, key_out,
// element_total, grow_wanted) and cfg (size_log2), all valid/ready.
// a front end takes operations into a two-entry command queue; a back end
// probes the slot memories one slot at a time, each probe a registered read
// and then an evaluate step. pop scans forward slot by slot from its finger.
// clear and every cfg write sweep all 2^SLOT_COUNT_LOG2 flag entries, one
// per cycle; after reset the same sweep runs while no operation is taken.
// a cfg write also clears the set without producing a result. when res is
// stalled the result holds and the queue can still take up to two more
// operations.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_top
  import oahs_pkg::*;
#(
  parameter int SLOT_COUNT_LOG2 = SlotCountLog2Dflt,
  parameter int KEY_WIDTH       = KeyWidthDflt,
  parameter int HASH_WIDTH      = HashWidthDflt
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  oahs_op_if.sink     op,
  oahs_cfg_if.sink    cfg,
  oahs_res_if.source  res
);

  localparam int CmdW = 3 + KEY_WIDTH + HASH_WIDTH;

  logic            cmd_valid, cmd_ready;
  logic [CmdW-1:0] cmd;

  oahs_front #(.KEY_WIDTH(KEY_WIDTH), .HASH_WIDTH(HASH_WIDTH), .CMD_W(CmdW)) u_front (
    .clk_i, .rst_ni, .op,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  oahs_back #(.SLOT_COUNT_LOG2(SLOT_COUNT_LOG2), .KEY_WIDTH(KEY_WIDTH),
              .HASH_WIDTH(HASH_WIDTH), .CMD_W(CmdW)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .cfg, .res
  );

endmodule : open_addressing_hash_set_top
`default_nettype wire
